@@ design/hsvrgb_pkg.sv @@
// Shared constants for the HSV to RGB pixel converter.
// Fixed-point formats, sector codes and reciprocal constants; no dependencies.
package hsvrgb_pkg;

   // Field widths of the transaction payload
   localparam int HUE_BITS     = 16;
   localparam int UNIT_BITS    = 9;
   localparam int CHANNEL_BITS = 8;

   // Hue fraction bits per degree and one 60-degree sector in hue units
   localparam int HUE_FRAC_BITS = 7;
   localparam int SECTOR        = 60 << HUE_FRAC_BITS;
   localparam int SECTOR_BITS   = $clog2(SECTOR);
   // Largest whole number of sectors a hue code can span
   localparam int WRAP_MAX      = ((1 << HUE_BITS) - 1) / SECTOR;
   localparam int WRAP_BITS     = $clog2(WRAP_MAX + 1);

   // Saturation and brightness: UNIT_ONE means 1.0
   localparam int UNIT_ONE = 256;

   // Internal terms carry 16 fraction bits; 1.0 needs one more bit
   localparam int F_BITS = 16;
   localparam int F_ONE  = 1 << F_BITS;
   localparam int T_BITS = F_BITS + 1;

   // f = (rem << 16) / SECTOR = (rem << REM_SHIFT) / DIV_ODD, done as a
   // multiply by a rounded-up reciprocal; exact while x * RECIP_ERR < 2^RECIP_SHIFT
   localparam int REM_SHIFT   = F_BITS - HUE_FRAC_BITS - 2;
   localparam int DIV_ODD     = 15;
   localparam int X_BITS      = SECTOR_BITS + REM_SHIFT;
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_M     = ((1 << RECIP_SHIFT) + DIV_ODD - 1) / DIV_ODD;
   localparam int RECIP_BITS  = $clog2(RECIP_M + 1);
   localparam int PROD_BITS   = X_BITS + RECIP_BITS;

   localparam int CH_MAX = (1 << CHANNEL_BITS) - 1;

   // Hue sector codes
   typedef enum logic [2:0] {
      SEC_RED_GREEN  = 3'd0,
      SEC_GREEN_RED  = 3'd1,
      SEC_GREEN_BLUE = 3'd2,
      SEC_BLUE_GREEN = 3'd3,
      SEC_BLUE_RED   = 3'd4,
      SEC_RED_BLUE   = 3'd5
   } sector_type;

   localparam int NUM_SECTORS = 6;

endpackage

@@ design/hsv_to_rgb_pixel.sv @@
// Throughput: one pixel per cycle; a stall on a held rsp_ result freezes all five stages.
// Stages: sector split, reciprocal multiply, f*s products, v*(1-x) products,
// sector mux and channel scaling.
// Reset (synchronous, active high) clears every stage valid bit; data
// registers are not reset.
module hsv_to_rgb_pixel
   import hsvrgb_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [HUE_BITS-1:0]     req_hue,
   input  logic [UNIT_BITS-1:0]    req_saturation,
   input  logic [UNIT_BITS-1:0]    req_brightness,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [CHANNEL_BITS-1:0] rsp_red,
   output logic [CHANNEL_BITS-1:0] rsp_green,
   output logic [CHANNEL_BITS-1:0] rsp_blue
);

   // Pipeline advances whenever the output register is free or being taken
   logic rsp_valid_ff;
   logic adv;
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // ---------------- Stage 1: clip units, split hue into sector and remainder
   logic                    v1_ff;
   sector_type              sec1_ff, sec1_in;
   logic [SECTOR_BITS-1:0]  rem1_ff, rem1_in;
   logic [UNIT_BITS-1:0]    s1_ff, s1_in, b1_ff, b1_in;
   logic [WRAP_BITS-1:0]    wraps;
   logic [HUE_BITS-1:0]     base;

   always_comb begin
      wraps = '0;
      for (int k = 1; k <= WRAP_MAX; k++) begin
         if (req_hue >= HUE_BITS'(k * SECTOR)) begin
            wraps = WRAP_BITS'(k);
         end
      end
      base    = HUE_BITS'(int'(wraps) * SECTOR);
      rem1_in = SECTOR_BITS'(req_hue - base);
      // Hue at or beyond 360 degrees wraps around the six sectors
      if (wraps >= WRAP_BITS'(NUM_SECTORS)) begin
         sec1_in = sector_type'(3'(wraps - WRAP_BITS'(NUM_SECTORS)));
      end else begin
         sec1_in = sector_type'(3'(wraps));
      end
      s1_in = (req_saturation > UNIT_BITS'(UNIT_ONE)) ? UNIT_BITS'(UNIT_ONE) : req_saturation;
      b1_in = (req_brightness > UNIT_BITS'(UNIT_ONE)) ? UNIT_BITS'(UNIT_ONE) : req_brightness;
   end

   // ---------------- Stage 2: f from remainder, p = v*(1-s)
   logic                    v2_ff;
   sector_type              sec2_ff;
   logic [F_BITS-1:0]       f2_ff, f2_in;
   logic [T_BITS-1:0]       p2_ff, p2_in;
   logic [UNIT_BITS-1:0]    s2_ff, b2_ff;
   logic [X_BITS-1:0]       rem_x;
   logic [PROD_BITS-1:0]    recip_prod;
   logic [2*UNIT_BITS-1:0]  p_prod;

   always_comb begin
      rem_x      = {rem1_ff, REM_SHIFT'(0)};
      recip_prod = PROD_BITS'(rem_x) * PROD_BITS'(RECIP_M);
      f2_in      = F_BITS'(recip_prod >> RECIP_SHIFT);
      p_prod     = (2*UNIT_BITS)'(b1_ff) * (2*UNIT_BITS)'(UNIT_BITS'(UNIT_ONE) - s1_ff);
      p2_in      = T_BITS'(p_prod);
   end

   // ---------------- Stage 3: f*s and (1-f)*s, 16 fraction bits
   localparam int FS_BITS = T_BITS + UNIT_BITS;
   logic                    v3_ff;
   sector_type              sec3_ff;
   logic [T_BITS-1:0]       fs3_ff, fs3_in, gs3_ff, gs3_in, p3_ff;
   logic [UNIT_BITS-1:0]    b3_ff, s3_ff;
   logic [T_BITS-1:0]       one_minus_f;
   logic [FS_BITS-1:0]      fs_prod, gs_prod;

   always_comb begin
      one_minus_f = T_BITS'(F_ONE) - T_BITS'(f2_ff);
      fs_prod     = FS_BITS'(f2_ff) * FS_BITS'(s2_ff);
      gs_prod     = FS_BITS'(one_minus_f) * FS_BITS'(s2_ff);
      fs3_in      = T_BITS'(fs_prod >> (UNIT_BITS - 1));
      gs3_in      = T_BITS'(gs_prod >> (UNIT_BITS - 1));
   end

   // ---------------- Stage 4: q = v*(1-f*s), t = v*(1-(1-f)*s)
   logic                    v4_ff;
   sector_type              sec4_ff;
   logic [T_BITS-1:0]       q4_ff, q4_in, t4_ff, t4_in, p4_ff;
   logic [UNIT_BITS-1:0]    b4_ff;
   logic [FS_BITS-1:0]      q_prod, t_prod;

   always_comb begin
      q_prod = FS_BITS'(b3_ff) * FS_BITS'(T_BITS'(F_ONE) - fs3_ff);
      t_prod = FS_BITS'(b3_ff) * FS_BITS'(T_BITS'(F_ONE) - gs3_ff);
      q4_in  = T_BITS'(q_prod >> (UNIT_BITS - 1));
      t4_in  = T_BITS'(t_prod >> (UNIT_BITS - 1));
   end

   // ---------------- Stage 5: sector mux and channel scaling
   logic [CHANNEL_BITS-1:0] red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic [T_BITS-1:0]       v_term, r_term, g_term, b_term;

   function automatic logic [CHANNEL_BITS-1:0] to_channel(input logic [T_BITS-1:0] x);
      logic [T_BITS+CHANNEL_BITS-1:0] scaled;
      logic [T_BITS+CHANNEL_BITS-1:0] c;
      scaled = (T_BITS+CHANNEL_BITS)'(x) * (T_BITS+CHANNEL_BITS)'(CH_MAX);
      c      = scaled >> F_BITS;
      if (c > (T_BITS+CHANNEL_BITS)'(CH_MAX)) begin
         c = (T_BITS+CHANNEL_BITS)'(CH_MAX);
      end
      return CHANNEL_BITS'(c);
   endfunction

   always_comb begin
      v_term = {b4_ff, (T_BITS-UNIT_BITS)'(0)};
      case (sec4_ff)
         SEC_RED_GREEN: begin
            r_term = v_term; g_term = t4_ff;  b_term = p4_ff;
         end
         SEC_GREEN_RED: begin
            r_term = q4_ff;  g_term = v_term; b_term = p4_ff;
         end
         SEC_GREEN_BLUE: begin
            r_term = p4_ff;  g_term = v_term; b_term = t4_ff;
         end
         SEC_BLUE_GREEN: begin
            r_term = p4_ff;  g_term = q4_ff;  b_term = v_term;
         end
         SEC_BLUE_RED: begin
            r_term = t4_ff;  g_term = p4_ff;  b_term = v_term;
         end
         default: begin
            r_term = v_term; g_term = p4_ff;  b_term = q4_ff;
         end
      endcase
      red_in   = to_channel(r_term);
      green_in = to_channel(g_term);
      blue_in  = to_channel(b_term);
   end

   // Valid bits travel with the data and hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         rsp_valid_ff <= v4_ff;
      end
   end

   // Advance the data registers
   always_ff @(posedge clock) begin
      if (adv) begin
         sec1_ff  <= sec1_in;
         rem1_ff  <= rem1_in;
         s1_ff    <= s1_in;
         b1_ff    <= b1_in;

         sec2_ff  <= sec1_ff;
         f2_ff    <= f2_in;
         p2_ff    <= p2_in;
         s2_ff    <= s1_ff;
         b2_ff    <= b1_ff;

         sec3_ff  <= sec2_ff;
         fs3_ff   <= fs3_in;
         gs3_ff   <= gs3_in;
         p3_ff    <= p2_ff;
         s3_ff    <= s2_ff;
         b3_ff    <= b2_ff;

         sec4_ff  <= sec3_ff;
         q4_ff    <= q4_in;
         t4_ff    <= t4_in;
         p4_ff    <= p3_ff;
         b4_ff    <= b3_ff;

         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

   // Remainder after the sector split stays inside one sector
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> (rem1_ff < SECTOR_BITS'(SECTOR)))
      else $error("hue remainder outside one sector");

   // f*s and (1-f)*s must add up to s within one LSB
   a_fs_sum: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> (((T_BITS+1)'(fs3_ff) + (T_BITS+1)'(gs3_ff)
                  <= (T_BITS+1)'({s3_ff, (T_BITS-UNIT_BITS)'(0)})) &&
                 ((T_BITS+1)'(fs3_ff) + (T_BITS+1)'(gs3_ff) + (T_BITS+1)'(1)
                  >= (T_BITS+1)'({s3_ff, (T_BITS-UNIT_BITS)'(0)}))))
      else $error("f*s and (1-f)*s do not sum to s");

   // p never exceeds q or t, and q, t never exceed v
   a_term_order: assert property (@(posedge clock) disable iff (reset)
      v4_ff |-> (p4_ff <= q4_ff) && (p4_ff <= t4_ff) &&
                (q4_ff <= {b4_ff, (T_BITS-UNIT_BITS)'(0)}) &&
                (t4_ff <= {b4_ff, (T_BITS-UNIT_BITS)'(0)}))
      else $error("HSV terms out of order");

   // An empty last stage drains the output once it is taken
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !v4_ff) |=> !rsp_valid)
      else $error("output valid without a transaction behind it");

endmodule

@@ bench/tb_hsv_to_rgb_pixel.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for hsv_to_rgb_pixel: directed corner pixels, then random pixels.
// Depends on hsvrgb_pkg and the hsv_to_rgb_pixel RTL; results are checked in order.
module tb_hsv_to_rgb_pixel;
   import hsvrgb_pkg::*;

   localparam int CLOCK_PERIOD = 8;
   localparam int RESET_CYCLES = 6;
   localparam int RANDOM_PIXELS = 2000;
   localparam int CALM_FIRST = 900;
   localparam int CALM_LAST = 1300;
   localparam int IDLE_PERCENT = 29;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HUE_TOP = 6 * SECTOR - 1;
   localparam int UNIT_SHIFT = F_BITS - $clog2(UNIT_ONE);
   localparam logic [63:0] ONE64 = 64'(F_ONE);
   localparam logic [63:0] SECTOR64 = 64'(SECTOR);
   localparam logic [63:0] CH_MAX64 = 64'(CH_MAX);

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
   } rgb_type;

   // One directed pixel; known marks rows whose color is written out by hand
   typedef struct packed {
      logic                    known;
      logic [HUE_BITS-1:0]     hue;
      logic [UNIT_BITS-1:0]    sat;
      logic [UNIT_BITS-1:0]    bri;
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
   } pixel_case_type;

   localparam int NUM_DIRECTED = 24;
   localparam pixel_case_type DIRECTED_PIXELS [0:NUM_DIRECTED-1] = '{
      // black, white, zero brightness, pure primaries and secondaries
      '{1'b1, 16'd0,     9'd0,   9'd0,   8'd0,   8'd0,   8'd0},
      '{1'b1, 16'd0,     9'd0,   9'd256, 8'd255, 8'd255, 8'd255},
      '{1'b1, 16'd0,     9'd256, 9'd0,   8'd0,   8'd0,   8'd0},
      '{1'b1, 16'd0,     9'd256, 9'd256, 8'd255, 8'd0,   8'd0},
      '{1'b1, 16'd7680,  9'd256, 9'd256, 8'd255, 8'd255, 8'd0},
      '{1'b1, 16'd15360, 9'd256, 9'd256, 8'd0,   8'd255, 8'd0},
      '{1'b1, 16'd23040, 9'd256, 9'd256, 8'd0,   8'd255, 8'd255},
      '{1'b1, 16'd30720, 9'd256, 9'd256, 8'd0,   8'd0,   8'd255},
      '{1'b1, 16'd38400, 9'd256, 9'd256, 8'd255, 8'd0,   8'd255},
      // hue of a full turn wraps back to red
      '{1'b1, 16'd46080, 9'd256, 9'd256, 8'd255, 8'd0,   8'd0},
      // saturation and brightness above one clip to one
      '{1'b1, 16'd0,     9'd511, 9'd511, 8'd255, 8'd0,   8'd0},
      '{1'b1, 16'd12345, 9'd0,   9'd511, 8'd255, 8'd255, 8'd255},
      '{1'b1, 16'd65535, 9'd511, 9'd0,   8'd0,   8'd0,   8'd0},
      // remaining rows go through the predictor
      '{1'b0, 16'd46079, 9'd256, 9'd256, 8'd0,   8'd0,   8'd0},
      '{1'b0, 16'd65535, 9'd256, 9'd256, 8'd0,   8'd0,   8'd0},
      '{1'b0, 16'd3840,  9'd128, 9'd200, 8'd0,   8'd0,   8'd0},
      '{1'b0, 16'd11520, 9'd257, 9'd256, 8'd0,   8'd0,   8'd0},
      '{1'b0, 16'd19200, 9'd255, 9'd1,   8'd0,   8'd0,   8'd0},
      '{1'b0, 16'd26880, 9'd1,   9'd255, 8'd0,   8'd0,   8'd0},
      '{1'b0, 16'd34560, 9'd200, 9'd128, 8'd0,   8'd0,   8'd0},
      '{1'b0, 16'd42240, 9'd100, 9'd256, 8'd0,   8'd0,   8'd0},
      '{1'b0, 16'd7679,  9'd256, 9'd256, 8'd0,   8'd0,   8'd0},
      '{1'b0, 16'd1,     9'd256, 9'd256, 8'd0,   8'd0,   8'd0},
      '{1'b0, 16'd40000, 9'd300, 9'd300, 8'd0,   8'd0,   8'd0}
   };

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [HUE_BITS-1:0]     req_hue;
   logic [UNIT_BITS-1:0]    req_saturation;
   logic [UNIT_BITS-1:0]    req_brightness;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [CHANNEL_BITS-1:0] rsp_red;
   logic [CHANNEL_BITS-1:0] rsp_green;
   logic [CHANNEL_BITS-1:0] rsp_blue;

   rgb_type pending_rgb [$];
   int      mismatch_count = 0;
   int      cycle_count = 0;
   logic    calm = 1'b0;

   hsv_to_rgb_pixel u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Scale a 16-bit fraction to a channel code, clipping at full scale
   function automatic logic [CHANNEL_BITS-1:0] scale_channel(input logic [63:0] x16);
      logic [63:0] code;
      code = (CH_MAX64 * x16) >> F_BITS;
      if (code > CH_MAX64) code = CH_MAX64;
      return code[CHANNEL_BITS-1:0];
   endfunction

   // Six-sector HSV to RGB in 16-bit fixed point
   function automatic rgb_type predict_rgb(input logic [HUE_BITS-1:0] hue,
                                           input logic [UNIT_BITS-1:0] sat,
                                           input logic [UNIT_BITS-1:0] bri);
      logic [63:0] s16, v16, frac, p, q, t, r, g, b;
      sector_type  sec;
      rgb_type     res;
      s16 = 64'((sat > UNIT_BITS'(UNIT_ONE)) ? UNIT_BITS'(UNIT_ONE) : sat) << UNIT_SHIFT;
      v16 = 64'((bri > UNIT_BITS'(UNIT_ONE)) ? UNIT_BITS'(UNIT_ONE) : bri) << UNIT_SHIFT;
      sec = sector_type'(3'((hue / HUE_BITS'(SECTOR)) % HUE_BITS'(NUM_SECTORS)));
      frac = (64'(hue % HUE_BITS'(SECTOR)) << F_BITS) / SECTOR64;
      p = (v16 * (ONE64 - s16)) >> F_BITS;
      q = (v16 * (ONE64 - ((frac * s16) >> F_BITS))) >> F_BITS;
      t = (v16 * (ONE64 - (((ONE64 - frac) * s16) >> F_BITS))) >> F_BITS;
      case (sec)
         SEC_RED_GREEN: begin
            r = v16; g = t; b = p;
         end
         SEC_GREEN_RED: begin
            r = q; g = v16; b = p;
         end
         SEC_GREEN_BLUE: begin
            r = p; g = v16; b = t;
         end
         SEC_BLUE_GREEN: begin
            r = p; g = q; b = v16;
         end
         SEC_BLUE_RED: begin
            r = t; g = p; b = v16;
         end
         default: begin
            r = v16; g = p; b = q;
         end
      endcase
      res.red = scale_channel(r);
      res.green = scale_channel(g);
      res.blue = scale_channel(b);
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
   endtask

   // Offer one pixel after a random idle gap; log its color once accepted
   task automatic send_pixel(input logic [HUE_BITS-1:0] hue,
                             input logic [UNIT_BITS-1:0] sat,
                             input logic [UNIT_BITS-1:0] bri,
                             input rgb_type want);
      while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_hue <= hue;
      req_saturation <= sat;
      req_brightness <= bri;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rgb.push_back(want);
      @(negedge clock);
   endtask

   // Pick a unit value: mostly in range, with the ends and clipped values mixed in
   function automatic logic [UNIT_BITS-1:0] pick_unit();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 75) return UNIT_BITS'($urandom_range(0, UNIT_ONE));
      if (roll < 85) return ($urandom_range(0, 1) != 0) ? UNIT_BITS'(UNIT_ONE) : '0;
      return UNIT_BITS'($urandom_range(0, (1 << UNIT_BITS) - 1));
   endfunction

   // Stall the result channel at random, except in the calm stretch
   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
   end

   // Check each accepted result against the oldest expected color
   always @(posedge clock) begin
      rgb_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rgb.size() == 0) begin
            report_mismatch("result with nothing expected", rsp_red, 0);
         end else begin
            want = pending_rgb.pop_front();
            if (rsp_red !== want.red) report_mismatch("red", rsp_red, want.red);
            if (rsp_green !== want.green) report_mismatch("green", rsp_green, want.green);
            if (rsp_blue !== want.blue) report_mismatch("blue", rsp_blue, want.blue);
         end
      end
   end

   // Hard stop if the run hangs
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      logic [HUE_BITS-1:0]  hue;
      logic [UNIT_BITS-1:0] sat;
      logic [UNIT_BITS-1:0] bri;
      pixel_case_type       row;
      rgb_type              want;

      reset = 1'b1;
      req_valid = 1'b0;
      req_hue = '0;
      req_saturation = '0;
      req_brightness = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         row = DIRECTED_PIXELS[i];
         if (row.known) begin
            want.red = row.red;
            want.green = row.green;
            want.blue = row.blue;
         end else begin
            want = predict_rgb(row.hue, row.sat, row.bri);
         end
         send_pixel(row.hue, row.sat, row.bri, want);
      end

      // Random pixels, with a calm stretch where neither side idles
      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         calm = (i >= CALM_FIRST) && (i < CALM_LAST);
         if ($urandom_range(0, 99) < 80) hue = HUE_BITS'($urandom_range(0, HUE_TOP));
         else hue = HUE_BITS'($urandom_range(0, (1 << HUE_BITS) - 1));
         sat = pick_unit();
         bri = pick_unit();
         send_pixel(hue, sat, bri, predict_rgb(hue, sat, bri));
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      // Drain the pipeline, then settle
      while (pending_rgb.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
